/* design/sspq_pkg.sv */
// sspq_pkg: shared types and constants of the sphere set point query block
// no dependencies; every other design file refers to it by scoped names
`default_nettype none

package sspq_pkg;

  // item action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_ATOM_COUNT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_RADIUS = 1'd1;

  // field widths
  localparam int COUNT_W  = 13;
  localparam int RADIUS_W = 12;
  localparam int INFL_W   = 13;
  localparam int IDX_W    = 12;
  localparam int RSQ_W    = 24;
  localparam int ISQ_W    = 26;
  localparam int DIST_W   = 42;
  localparam int MARGIN_W = 25;
  localparam int SQ_IN_W  = 21;

  localparam logic [RADIUS_W-1:0] PROBE_RESET = 12'd358;
  localparam logic [DIST_W-1:0]   DIST_SAT    = 42'd3298534883328;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_FLUSH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

endpackage

`default_nettype wire

/* design/sspq_in_if.sv */
// sspq_in_if: input channel of the sphere set point query block
// depends on sspq_pkg for field widths
`default_nettype none

interface sspq_in_if #(
  parameter int COORD_BITS = 20
) ();
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic [sspq_pkg::IDX_W-1:0]          atom_index;
  logic signed [COORD_BITS-1:0]        pos_x;
  logic signed [COORD_BITS-1:0]        pos_y;
  logic signed [COORD_BITS-1:0]        pos_z;
  logic [sspq_pkg::RADIUS_W-1:0]       radius;

  modport source (
    output valid, action, atom_index, pos_x, pos_y, pos_z, radius,
    input  ready
  );
  modport sink (
    input  valid, action, atom_index, pos_x, pos_y, pos_z, radius,
    output ready
  );
endinterface

`default_nettype wire

/* design/sspq_out_if.sv */
// sspq_out_if: result channel of the sphere set point query block
// depends on sspq_pkg for field widths
`default_nettype none

interface sspq_out_if ();
  logic                                 valid;
  logic                                 ready;
  logic                                 in_atom;
  logic                                 near_surface;
  logic [sspq_pkg::IDX_W-1:0]           nearest_index;
  logic [sspq_pkg::DIST_W-1:0]          nearest_dist_sq;
  logic [sspq_pkg::IDX_W-1:0]           deepest_index;
  logic signed [sspq_pkg::MARGIN_W-1:0] deepest_margin;

  modport source (
    output valid, in_atom, near_surface, nearest_index, nearest_dist_sq,
           deepest_index, deepest_margin,
    input  ready
  );
  modport sink (
    input  valid, in_atom, near_surface, nearest_index, nearest_dist_sq,
           deepest_index, deepest_margin,
    output ready
  );
endinterface

`default_nettype wire

/* design/sspq_dist.sv */
// sspq_dist: two-stage squared distance unit, point to one stored centre
// stage a squares the per-axis offsets, stage b clamps and sums; uses sspq_pkg
`default_nettype none

module sspq_dist #(
  parameter int COORD_BITS = 20,
  parameter int TAG_W      = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sspq_pkg::ctl_t                  ctl_i,
  input  logic [TAG_W-1:0]                tag_i,
  input  logic signed [COORD_BITS-1:0]    cx_i,
  input  logic signed [COORD_BITS-1:0]    cy_i,
  input  logic signed [COORD_BITS-1:0]    cz_i,
  input  logic signed [COORD_BITS-1:0]    px_i,
  input  logic signed [COORD_BITS-1:0]    py_i,
  input  logic signed [COORD_BITS-1:0]    pz_i,
  input  logic [sspq_pkg::RSQ_W-1:0]      rsq_i,
  input  logic [sspq_pkg::ISQ_W-1:0]      isq_i,
  output sspq_pkg::ctl_t                  ctl_o,
  output logic [TAG_W-1:0]                tag_o,
  output logic [sspq_pkg::DIST_W-1:0]     d_o,
  output logic [sspq_pkg::RSQ_W-1:0]      rsq_o,
  output logic [sspq_pkg::ISQ_W-1:0]      isq_o
);

  localparam int EW = (COORD_BITS + 1 > sspq_pkg::SQ_IN_W) ? COORD_BITS + 1
                                                           : sspq_pkg::SQ_IN_W + 1;
  localparam int SUM_W = sspq_pkg::DIST_W + 2;

  logic signed [COORD_BITS-1:0] cen [3];
  logic signed [COORD_BITS-1:0] pnt [3];
  logic [COORD_BITS:0]          dif [3];
  logic [COORD_BITS:0]          mag [3];
  logic [EW-1:0]                mag_e [3];
  logic [sspq_pkg::SQ_IN_W-1:0] mag_lo [3];
  logic [sspq_pkg::DIST_W-1:0]  sq [3];
  logic                         big [3];

  sspq_pkg::ctl_t               ctl_a_r;
  logic [TAG_W-1:0]             tag_a_r;
  logic [sspq_pkg::RSQ_W-1:0]   rsq_a_r;
  logic [sspq_pkg::ISQ_W-1:0]   isq_a_r;
  logic [sspq_pkg::DIST_W-1:0]  sq_a_r [3];
  logic                         big_a_r [3];

  logic [sspq_pkg::DIST_W-1:0]  clamp [3];
  logic [SUM_W-1:0]             sum;
  logic [sspq_pkg::DIST_W-1:0]  d_nxt;

  sspq_pkg::ctl_t               ctl_b_r;
  logic [TAG_W-1:0]             tag_b_r;
  logic [sspq_pkg::RSQ_W-1:0]   rsq_b_r;
  logic [sspq_pkg::ISQ_W-1:0]   isq_b_r;
  logic [sspq_pkg::DIST_W-1:0]  d_b_r;

  assign cen[0] = cx_i;
  assign cen[1] = cy_i;
  assign cen[2] = cz_i;
  assign pnt[0] = px_i;
  assign pnt[1] = py_i;
  assign pnt[2] = pz_i;

  // offsets of 2^21 and more square past the saturation value
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dif[k]    = {cen[k][COORD_BITS-1], cen[k]} - {pnt[k][COORD_BITS-1], pnt[k]};
      mag[k]    = dif[k][COORD_BITS] ? (~dif[k] + 1'b1) : dif[k];
      mag_e[k]  = EW'(mag[k]);
      big[k]    = |mag_e[k][EW-1:sspq_pkg::SQ_IN_W];
      mag_lo[k] = mag_e[k][sspq_pkg::SQ_IN_W-1:0];
      sq[k]     = mag_lo[k] * mag_lo[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
    end else begin
      ctl_a_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    tag_a_r <= tag_i;
    rsq_a_r <= rsq_i;
    isq_a_r <= isq_i;
    for (int k = 0; k < 3; k++) begin
      sq_a_r[k]  <= sq[k];
      big_a_r[k] <= big[k];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (big_a_r[k] || (sq_a_r[k] > sspq_pkg::DIST_SAT)) begin
        clamp[k] = sspq_pkg::DIST_SAT;
      end else begin
        clamp[k] = sq_a_r[k];
      end
    end
    sum = {2'b0, clamp[0]} + {2'b0, clamp[1]} + {2'b0, clamp[2]};
    if (sum > {2'b0, sspq_pkg::DIST_SAT}) begin
      d_nxt = sspq_pkg::DIST_SAT;
    end else begin
      d_nxt = sum[sspq_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r <= '0;
    end else begin
      ctl_b_r <= ctl_a_r;
    end
  end

  always_ff @(posedge clk) begin
    tag_b_r <= tag_a_r;
    rsq_b_r <= rsq_a_r;
    isq_b_r <= isq_a_r;
    d_b_r   <= d_nxt;
  end

  assign ctl_o = ctl_b_r;
  assign tag_o = tag_b_r;
  assign d_o   = d_b_r;
  assign rsq_o = rsq_b_r;
  assign isq_o = isq_b_r;

endmodule

`default_nettype wire

/* design/sphere_set_point_query_top.sv */
// sphere_set_point_query_top: atom store with brute-force point query scan
// uses sspq_pkg, sspq_in_if, sspq_out_if and sspq_dist
//
//  channel  | dir | handshake        | contents
//  ---------+-----+------------------+-------------------------------------------
//  in_ch    | in  | valid / ready    | action, atom_index, pos_x/y/z, radius
//  out_ch   | out | valid / ready    | in_atom, near_surface, nearest, deepest
//  cfg_*    | in  | cfg_we           | cfg_index, cfg_data (atom_count, probe)
//
// a load beat: capture, then slot reduction and radius squares with the write
// a query beat scans min(atom_count, MAX_ATOMS) atoms; the single
// read port of the atom memory delivers one atom per cycle to the distance pipe
// a finished result waits in the output register; loads are taken meanwhile
// reset clears control and configuration registers only; data and memory stay unknown
`default_nettype none

module sphere_set_point_query_top #(
  parameter int MAX_ATOMS  = 4096,
  parameter int COORD_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  sspq_in_if.sink                             in_ch,
  sspq_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [sspq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sspq_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW    = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int CW    = $clog2(MAX_ATOMS + 1);
  localparam int LOG_M = $clog2(MAX_ATOMS);
  localparam int SHIFT = sspq_pkg::IDX_W + LOG_M;
  localparam longint RECIP = ((longint'(1) <<< SHIFT) + longint'(MAX_ATOMS) - 1)
                             / longint'(MAX_ATOMS);
  localparam int RW    = $clog2(RECIP + 1);
  localparam int PW    = sspq_pkg::IDX_W + RW;
  localparam int QW    = sspq_pkg::IDX_W + CW;
  localparam int MW    = 3 * COORD_BITS + sspq_pkg::RSQ_W + sspq_pkg::ISQ_W;
  localparam logic [RW-1:0] RECIP_V = RW'(RECIP);
  localparam logic [CW-1:0] MAX_V   = CW'(MAX_ATOMS);

  sspq_pkg::state_t state_r, state_nxt;

  logic [sspq_pkg::COUNT_W-1:0]  atom_count_r;
  logic [sspq_pkg::RADIUS_W-1:0] probe_r;

  logic                          in_ready;
  logic                          in_acc;
  logic [CW-1:0]                 n_cap;
  logic [CW-1:0]                 n_r;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [CW-1:0]                 cnt_inc;
  logic                          issue;
  logic                          mem_we;
  logic                          acc_init;
  logic                          out_load;

  logic signed [COORD_BITS-1:0]  px_r, py_r, pz_r;
  logic [sspq_pkg::IDX_W-1:0]    aidx_r;
  logic [sspq_pkg::RADIUS_W-1:0] rad_r;
  logic [sspq_pkg::INFL_W-1:0]   infl_r;
  logic [PW-1:0]                 quo_prod;
  logic [sspq_pkg::IDX_W-1:0]    quo_r;
  logic [QW-1:0]                 quo_m;
  logic [QW-1:0]                 slot;
  logic [sspq_pkg::RSQ_W-1:0]    rsq_w;
  logic [sspq_pkg::ISQ_W-1:0]    isq_w;

  logic [MW-1:0]                 mem [MAX_ATOMS];
  logic [MW-1:0]                 wr_data;
  logic [MW-1:0]                 rd_q;

  sspq_pkg::ctl_t                ctl1_r;
  logic [AW-1:0]                 idx1_r;

  sspq_pkg::ctl_t                ctl3;
  logic [AW-1:0]                 idx3;
  logic [sspq_pkg::DIST_W-1:0]   d3;
  logic [sspq_pkg::RSQ_W-1:0]    rsq3;
  logic [sspq_pkg::ISQ_W-1:0]    isq3;

  logic                          lt_r;
  logic                          lt_i;
  logic signed [sspq_pkg::MARGIN_W-1:0] margin;

  logic                          inside_r;
  logic                          near_r;
  logic [sspq_pkg::DIST_W-1:0]   best_d_r;
  logic [AW-1:0]                 best_i_r;
  logic signed [sspq_pkg::MARGIN_W-1:0] deep_m_r;
  logic [AW-1:0]                 deep_i_r;

  logic                          out_valid_r;
  logic                          o_in_atom_r;
  logic                          o_near_r;
  logic [sspq_pkg::IDX_W-1:0]    o_near_idx_r;
  logic [sspq_pkg::DIST_W-1:0]   o_dist_r;
  logic [sspq_pkg::IDX_W-1:0]    o_deep_idx_r;
  logic signed [sspq_pkg::MARGIN_W-1:0] o_margin_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atom_count_r <= '0;
      probe_r      <= sspq_pkg::PROBE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sspq_pkg::REG_ATOM_COUNT:   atom_count_r <= cfg_data[sspq_pkg::COUNT_W-1:0];
        sspq_pkg::REG_PROBE_RADIUS: probe_r      <= cfg_data[sspq_pkg::RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(atom_count_r) > 32'(MAX_ATOMS)) begin
      n_cap = MAX_V;
    end else begin
      n_cap = CW'(atom_count_r);
    end
  end

  assign in_ready    = (state_r == sspq_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;
  assign cnt_inc     = CW'(cnt_r + 1'b1);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sspq_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    issue     = 1'b0;
    mem_we    = 1'b0;
    acc_init  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      sspq_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.action == sspq_pkg::ACT_LOAD) begin
            state_nxt = sspq_pkg::ST_LOAD;
          end else begin
            acc_init  = 1'b1;
            cnt_nxt   = '0;
            state_nxt = (n_cap == '0) ? sspq_pkg::ST_FINISH : sspq_pkg::ST_SCAN;
          end
        end
      end
      sspq_pkg::ST_LOAD: begin
        mem_we    = 1'b1;
        state_nxt = sspq_pkg::ST_IDLE;
      end
      sspq_pkg::ST_SCAN: begin
        issue   = 1'b1;
        cnt_nxt = cnt_inc;
        if (cnt_inc == n_r) begin
          state_nxt = sspq_pkg::ST_FLUSH;
        end
      end
      sspq_pkg::ST_FLUSH: begin
        if (ctl3.valid && ctl3.last) begin
          state_nxt = sspq_pkg::ST_FINISH;
        end
      end
      sspq_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = sspq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sspq_pkg::ST_IDLE;
    endcase
  end

  // beat capture; slot quotient by reciprocal multiply
  assign quo_prod = in_ch.atom_index * RECIP_V;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r   <= in_ch.pos_x;
      py_r   <= in_ch.pos_y;
      pz_r   <= in_ch.pos_z;
      aidx_r <= in_ch.atom_index;
      rad_r  <= in_ch.radius;
      infl_r <= sspq_pkg::INFL_W'(in_ch.radius) + sspq_pkg::INFL_W'(probe_r);
      quo_r  <= sspq_pkg::IDX_W'(quo_prod >> SHIFT);
      n_r    <= n_cap;
    end
  end

  assign quo_m   = quo_r * MAX_V;
  assign slot    = QW'(aidx_r) - quo_m;
  assign rsq_w   = rad_r * rad_r;
  assign isq_w   = infl_r * infl_r;
  assign wr_data = {px_r, py_r, pz_r, rsq_w, isq_w};

  // atom memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot[AW-1:0]] <= wr_data;
    end
    rd_q <= mem[cnt_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else begin
      ctl1_r.valid <= issue;
      ctl1_r.last  <= issue && (cnt_inc == n_r);
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= cnt_r[AW-1:0];
  end

  sspq_dist #(
    .COORD_BITS (COORD_BITS),
    .TAG_W      (AW)
  ) u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl1_r),
    .tag_i (idx1_r),
    .cx_i  (rd_q[MW-1 -: COORD_BITS]),
    .cy_i  (rd_q[MW-COORD_BITS-1 -: COORD_BITS]),
    .cz_i  (rd_q[MW-2*COORD_BITS-1 -: COORD_BITS]),
    .px_i  (px_r),
    .py_i  (py_r),
    .pz_i  (pz_r),
    .rsq_i (rd_q[sspq_pkg::ISQ_W+sspq_pkg::RSQ_W-1 -: sspq_pkg::RSQ_W]),
    .isq_i (rd_q[sspq_pkg::ISQ_W-1:0]),
    .ctl_o (ctl3),
    .tag_o (idx3),
    .d_o   (d3),
    .rsq_o (rsq3),
    .isq_o (isq3)
  );

  // accumulate over the scan
  assign lt_r   = d3 < sspq_pkg::DIST_W'(rsq3);
  assign lt_i   = d3 < sspq_pkg::DIST_W'(isq3);
  assign margin = {1'b0, d3[sspq_pkg::RSQ_W-1:0]} - {1'b0, rsq3};

  always_ff @(posedge clk) begin
    if (acc_init) begin
      inside_r <= 1'b0;
      near_r   <= 1'b0;
      best_d_r <= sspq_pkg::DIST_SAT;
      best_i_r <= '0;
      deep_m_r <= '0;
      deep_i_r <= '0;
    end else if (ctl3.valid) begin
      if (lt_r) begin
        inside_r <= 1'b1;
        if (margin < deep_m_r) begin
          deep_m_r <= margin;
          deep_i_r <= idx3;
        end
      end
      if (lt_i) begin
        near_r <= 1'b1;
      end
      if ((d3 < best_d_r) || (idx3 == '0)) begin
        best_d_r <= d3;
        best_i_r <= idx3;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_in_atom_r  <= inside_r;
      o_near_r     <= near_r;
      o_near_idx_r <= sspq_pkg::IDX_W'(best_i_r);
      o_dist_r     <= best_d_r;
      o_deep_idx_r <= sspq_pkg::IDX_W'(deep_i_r);
      o_margin_r   <= deep_m_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.in_atom         = o_in_atom_r;
  assign out_ch.near_surface    = o_near_r;
  assign out_ch.nearest_index   = o_near_idx_r;
  assign out_ch.nearest_dist_sq = o_dist_r;
  assign out_ch.deepest_index   = o_deep_idx_r;
  assign out_ch.deepest_margin  = o_margin_r;

endmodule

`default_nettype wire

/* design/sspq_chk.sv */
// sspq_chk: port-level checks of the sphere set point query block
// uses sspq_pkg; bound to sphere_set_point_query_top at the end of this file
`default_nettype none

module sspq_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 in_action,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic                                 out_in_atom,
  input logic                                 out_near_surface,
  input logic [sspq_pkg::IDX_W-1:0]           out_nearest_index,
  input logic [sspq_pkg::DIST_W-1:0]          out_nearest_dist_sq,
  input logic [sspq_pkg::IDX_W-1:0]           out_deepest_index,
  input logic signed [sspq_pkg::MARGIN_W-1:0] out_deepest_margin
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_in_atom)
      && $stable(out_near_surface) && $stable(out_nearest_index)
      && $stable(out_nearest_dist_sq) && $stable(out_deepest_index)
      && $stable(out_deepest_margin))
    else $error("result beat changed while stalled");

  // inflated spheres contain the plain ones
  a_near_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_atom |-> out_near_surface)
    else $error("in_atom without near_surface");

  // margin sign tracks enclosure
  a_margin_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_in_atom == out_deepest_margin[sspq_pkg::MARGIN_W-1]))
    else $error("deepest_margin sign disagrees with in_atom");

  a_no_deep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_atom |-> (out_deepest_margin == '0)
      && (out_deepest_index == '0))
    else $error("deepest fields set with no enclosing atom");

  // a query occupies the block
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == sspq_pkg::ACT_QUERY) |=> !in_ready)
    else $error("input ready right after a query beat");

endmodule

bind sphere_set_point_query_top sspq_chk u_sspq_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .in_action           (in_ch.action),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_in_atom         (out_ch.in_atom),
  .out_near_surface    (out_ch.near_surface),
  .out_nearest_index   (out_ch.nearest_index),
  .out_nearest_dist_sq (out_ch.nearest_dist_sq),
  .out_deepest_index   (out_ch.deepest_index),
  .out_deepest_margin  (out_ch.deepest_margin)
);

`default_nettype wire
